// ----- hw/rtl/axis_angle_vector_rotate_core_assert.svh -----
// assertion macros used by the rtl queue module of the rotate core
// no dependencies
`ifndef AXIS_ANGLE_VECTOR_ROTATE_CORE_ASSERT_SVH
`define AXIS_ANGLE_VECTOR_ROTATE_CORE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define AAVR_ASSERT(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define AAVR_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/aavr_pkg.sv -----
// types, constants and the arctangent table of the rotate core
// no dependencies
package aavr_pkg;

    localparam int COMP_WIDTH       = 16;
    localparam int FRAC_BITS        = COMP_WIDTH - 4;
    localparam int ANGLE_WIDTH      = 16;
    localparam int ANGLE_FRAC       = 13;
    localparam int TRIG_FRAC        = 30;
    localparam int TRIG_WIDTH       = 34;
    localparam int ATAN_ENTRIES     = 30;
    localparam int ATAN_IDX_WIDTH   = 5;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF  = 4;

    typedef logic signed [COMP_WIDTH-1:0]  comp_t;
    typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
    typedef logic signed [TRIG_WIDTH-1:0]  trig_t;

    localparam angle_t ANGLE_LIMIT  = 16'sd25736;
    localparam trig_t  PI_Q30       = 34'sd3373259426;
    localparam trig_t  HALF_PI_Q30  = 34'sd1686629713;
    localparam trig_t  CORDIC_START = 34'sh026DD3B6A;
    localparam trig_t  ONE_Q30      = 34'sd1073741824;

    typedef struct packed {
        comp_t  vec_x;
        comp_t  vec_y;
        comp_t  vec_z;
        comp_t  axis_x;
        comp_t  axis_y;
        comp_t  axis_z;
        angle_t turn_angle;
    } in_item_t;

    typedef struct packed {
        comp_t rot_x;
        comp_t rot_y;
        comp_t rot_z;
    } out_item_t;

    // classified item handed from front to back
    typedef struct packed {
        comp_t vec_x;
        comp_t vec_y;
        comp_t vec_z;
        comp_t axis_x;
        comp_t axis_y;
        comp_t axis_z;
        trig_t z;
        logic  flip;
    } job_t;

    function automatic trig_t atan_q30(input logic [ATAN_IDX_WIDTH-1:0] idx);
        trig_t r;
        case (idx)
            5'd0:    r = 34'sh03243F6A8;
            5'd1:    r = 34'sh01DAC6705;
            5'd2:    r = 34'sh00FADBAFC;
            5'd3:    r = 34'sh007F56EA6;
            5'd4:    r = 34'sh003FEAB76;
            5'd5:    r = 34'sh001FFD55B;
            5'd6:    r = 34'sh000FFFAAA;
            5'd7:    r = 34'sh0007FFF55;
            5'd8:    r = 34'sh0003FFFEA;
            5'd9:    r = 34'sh0001FFFFD;
            5'd10:   r = 34'sh0000FFFFF;
            5'd11:   r = 34'sh00007FFFF;
            5'd12:   r = 34'sh00003FFFF;
            5'd13:   r = 34'sh00001FFFF;
            5'd14:   r = 34'sh00000FFFF;
            5'd15:   r = 34'sh000007FFF;
            5'd16:   r = 34'sh000003FFF;
            5'd17:   r = 34'sh000001FFF;
            5'd18:   r = 34'sh000000FFF;
            5'd19:   r = 34'sh0000007FF;
            5'd20:   r = 34'sh0000003FF;
            5'd21:   r = 34'sh0000001FF;
            5'd22:   r = 34'sh0000000FF;
            5'd23:   r = 34'sh00000007F;
            5'd24:   r = 34'sh00000003F;
            5'd25:   r = 34'sh00000001F;
            5'd26:   r = 34'sh00000000F;
            5'd27:   r = 34'sh000000007;
            5'd28:   r = 34'sh000000003;
            5'd29:   r = 34'sh000000001;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/aavr_front.sv -----
// front end: accepts input transfers, clamps and folds the angle
// depends on aavr_pkg
module aavr_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  aavr_pkg::in_item_t s_item,
    output logic              q_valid,
    input  logic              q_ready,
    output aavr_pkg::job_t    q_job
);

    aavr_pkg::angle_t ang;
    aavr_pkg::trig_t  z_wide;
    aavr_pkg::job_t   job_next;
    aavr_pkg::job_t   job_reg;
    logic             valid_reg;

    always_comb begin
        ang = s_item.turn_angle;
        if (ang > aavr_pkg::ANGLE_LIMIT) begin
            ang = aavr_pkg::ANGLE_LIMIT;
        end else if (ang < -aavr_pkg::ANGLE_LIMIT) begin
            ang = -aavr_pkg::ANGLE_LIMIT;
        end
        z_wide = aavr_pkg::trig_t'(ang) <<< (aavr_pkg::TRIG_FRAC - aavr_pkg::ANGLE_FRAC);

        job_next.vec_x  = s_item.vec_x;
        job_next.vec_y  = s_item.vec_y;
        job_next.vec_z  = s_item.vec_z;
        job_next.axis_x = s_item.axis_x;
        job_next.axis_y = s_item.axis_y;
        job_next.axis_z = s_item.axis_z;
        job_next.z      = z_wide;
        job_next.flip   = 1'b0;
        // fold into the cordic range, negate sine and cosine later
        if (z_wide > aavr_pkg::HALF_PI_Q30) begin
            job_next.z    = z_wide - aavr_pkg::PI_Q30;
            job_next.flip = 1'b1;
        end else if (z_wide < -aavr_pkg::HALF_PI_Q30) begin
            job_next.z    = z_wide + aavr_pkg::PI_Q30;
            job_next.flip = 1'b1;
        end
    end

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_job   = job_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            job_reg <= job_next;
        end
    end

endmodule

// ----- hw/rtl/aavr_queue.sv -----
// short queue between front and back end
// depends on aavr_pkg and the assertion header
`include "axis_angle_vector_rotate_core_assert.svh"
module aavr_queue #(
    parameter int DEPTH = aavr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  aavr_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output aavr_pkg::job_t pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    aavr_pkg::job_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_fire) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop_fire) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push_fire && !pop_fire) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop_fire && !push_fire) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `AAVR_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH), "queue count above depth")
    `AAVR_ASSERT_IMPL(a_push_only, aclk, aresetn, push_fire && !pop_fire, count_reg == $past(count_reg) + CNT_W'(1), "queue count missed a push")
    `AAVR_ASSERT_IMPL(a_pop_only, aclk, aresetn, pop_fire && !push_fire, count_reg == $past(count_reg) - CNT_W'(1), "queue count missed a pop")
    `AAVR_ASSERT_IMPL(a_push_pop, aclk, aresetn, push_fire && pop_fire, $stable(count_reg), "queue count moved on push and pop")

endmodule

// ----- hw/rtl/aavr_back.sv -----
// back end: products, pipelined cordic, rodrigues combine and saturation
// depends on aavr_pkg
module aavr_back #(
    parameter int STEPS = aavr_pkg::CORDIC_STEPS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  aavr_pkg::job_t      in_job,
    output logic                m_valid,
    input  logic                m_ready,
    output aavr_pkg::out_item_t m_item
);

    localparam int W      = aavr_pkg::COMP_WIDTH;
    localparam int FRAC   = aavr_pkg::FRAC_BITS;
    localparam int TW     = aavr_pkg::TRIG_WIDTH;
    localparam int TF     = aavr_pkg::TRIG_FRAC;
    localparam int N      = (STEPS > aavr_pkg::ATAN_ENTRIES) ? aavr_pkg::ATAN_ENTRIES : STEPS;
    localparam int PROD_W = 2 * W;
    localparam int SHP_W  = PROD_W - FRAC;
    localparam int CR_W   = SHP_W + 1;
    localparam int DOT_W  = SHP_W + 2;
    localparam int M_W    = DOT_W + 2;
    localparam int CV_W   = W + 2;
    localparam int SC_W   = CR_W + 2;
    localparam int KM_W   = W + M_W - FRAC;
    localparam int SUM_W  = KM_W + 2;

    typedef struct packed {
        logic [2:0][W-1:0]    k;
        logic [2:0][W-1:0]    v;
        logic [2:0][CR_W-1:0] cr;
        logic [DOT_W-1:0]     dot;
        logic                 flip;
    } carry_t;

    logic adv;

    // stage 0: the nine products k[i] * v[j]
    logic [2:0][W-1:0]         in_k;
    logic [2:0][W-1:0]         in_v;
    logic signed [PROD_W-1:0]  prod_reg [3][3];
    logic [2:0][W-1:0]         p0_k_reg;
    logic [2:0][W-1:0]         p0_v_reg;
    aavr_pkg::trig_t           p0_z_reg;
    logic                      p0_flip_reg;
    logic                      p0_valid_reg;

    // stage 1: cross and dot, then cordic stages
    logic signed [SHP_W-1:0]   sh [3][3];
    carry_t                    p1_next;
    carry_t                    st_reg [N+1];
    aavr_pkg::trig_t           x_reg [N+1];
    aavr_pkg::trig_t           y_reg [N+1];
    aavr_pkg::trig_t           z_reg [N+1];
    logic                      vld_reg [N+1];

    // stage 2: sine, cosine, one minus cosine
    aavr_pkg::trig_t           c_reg;
    aavr_pkg::trig_t           s_reg;
    aavr_pkg::trig_t           omc_reg;
    carry_t                    p2_carry_reg;
    logic                      p2_valid_reg;

    // stage 3
    logic signed [TW+DOT_W-1:0] mprod;
    logic signed [TW+W-1:0]     cvprod [3];
    logic signed [M_W-1:0]      m_reg;
    logic signed [CV_W-1:0]     cv_reg [3];
    aavr_pkg::trig_t            s3_reg;
    carry_t                     p3_carry_reg;
    logic                       p3_valid_reg;

    // stage 4
    logic signed [TW+CR_W-1:0]  scprod [3];
    logic signed [W+M_W-1:0]    kmprod [3];
    logic signed [SC_W-1:0]     sc_reg [3];
    logic signed [KM_W-1:0]     km_reg [3];
    logic signed [CV_W-1:0]     cv4_reg [3];
    logic                       p4_valid_reg;

    // output
    logic signed [SUM_W-1:0]    sum [3];
    aavr_pkg::comp_t            sat [3];
    aavr_pkg::out_item_t        out_reg;
    logic                       out_valid_reg;

    assign adv      = !out_valid_reg || m_ready;
    assign in_ready = adv;
    assign m_valid  = out_valid_reg;
    assign m_item   = out_reg;

    assign in_k = {in_job.axis_z, in_job.axis_y, in_job.axis_x};
    assign in_v = {in_job.vec_z, in_job.vec_y, in_job.vec_x};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_valid_reg  <= 1'b0;
            for (int i = 0; i <= N; i++) begin
                vld_reg[i] <= 1'b0;
            end
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            p0_valid_reg <= in_valid;
            vld_reg[0]   <= p0_valid_reg;
            for (int i = 0; i < N; i++) begin
                vld_reg[i+1] <= vld_reg[i];
            end
            p2_valid_reg  <= vld_reg[N];
            p3_valid_reg  <= p2_valid_reg;
            p4_valid_reg  <= p3_valid_reg;
            out_valid_reg <= p4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    prod_reg[i][j] <= $signed(in_k[i]) * $signed(in_v[j]);
                end
            end
            p0_k_reg    <= in_k;
            p0_v_reg    <= in_v;
            p0_z_reg    <= in_job.z;
            p0_flip_reg <= in_job.flip;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                sh[i][j] = SHP_W'(prod_reg[i][j] >>> FRAC);
            end
        end
        p1_next.k     = p0_k_reg;
        p1_next.v     = p0_v_reg;
        p1_next.cr[0] = CR_W'(sh[1][2]) - CR_W'(sh[2][1]);
        p1_next.cr[1] = CR_W'(sh[2][0]) - CR_W'(sh[0][2]);
        p1_next.cr[2] = CR_W'(sh[0][1]) - CR_W'(sh[1][0]);
        p1_next.dot   = DOT_W'(sh[0][0]) + DOT_W'(sh[1][1]) + DOT_W'(sh[2][2]);
        p1_next.flip  = p0_flip_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg[0] <= p1_next;
            x_reg[0]  <= aavr_pkg::CORDIC_START;
            y_reg[0]  <= '0;
            z_reg[0]  <= p0_z_reg;
            for (int i = 0; i < N; i++) begin
                st_reg[i+1] <= st_reg[i];
                if (!z_reg[i][TW-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i]
                        - aavr_pkg::atan_q30(aavr_pkg::ATAN_IDX_WIDTH'(i));
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i]
                        + aavr_pkg::atan_q30(aavr_pkg::ATAN_IDX_WIDTH'(i));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (st_reg[N].flip) begin
                c_reg   <= -x_reg[N];
                s_reg   <= -y_reg[N];
                omc_reg <= aavr_pkg::ONE_Q30 + x_reg[N];
            end else begin
                c_reg   <= x_reg[N];
                s_reg   <= y_reg[N];
                omc_reg <= aavr_pkg::ONE_Q30 - x_reg[N];
            end
            p2_carry_reg <= st_reg[N];
        end
    end

    always_comb begin
        mprod = omc_reg * $signed(p2_carry_reg.dot);
        for (int j = 0; j < 3; j++) begin
            cvprod[j] = c_reg * $signed(p2_carry_reg.v[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_reg <= M_W'(mprod >>> TF);
            for (int j = 0; j < 3; j++) begin
                cv_reg[j] <= CV_W'(cvprod[j] >>> TF);
            end
            s3_reg       <= s_reg;
            p3_carry_reg <= p2_carry_reg;
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            scprod[j] = s3_reg * $signed(p3_carry_reg.cr[j]);
            kmprod[j] = $signed(p3_carry_reg.k[j]) * m_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                sc_reg[j]  <= SC_W'(scprod[j] >>> TF);
                km_reg[j]  <= KM_W'(kmprod[j] >>> FRAC);
                cv4_reg[j] <= cv_reg[j];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            sum[j] = SUM_W'(cv4_reg[j]) + SUM_W'(sc_reg[j]) + SUM_W'(km_reg[j]);
            if (sum[j][SUM_W-1:W-1] == '0 || sum[j][SUM_W-1:W-1] == '1) begin
                sat[j] = W'(sum[j]);
            end else if (sum[j][SUM_W-1]) begin
                sat[j] = {1'b1, {(W-1){1'b0}}};
            end else begin
                sat[j] = {1'b0, {(W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg.rot_x <= sat[0];
            out_reg.rot_y <= sat[1];
            out_reg.rot_z <= sat[2];
        end
    end

endmodule

// ----- hw/rtl/axis_angle_vector_rotate_core.sv -----
// top level of the axis-angle vector rotate core
// depends on aavr_pkg, aavr_front, aavr_queue, aavr_back
// usage:
//   s_valid/s_ready/s_item carry one transfer per item: vector, unit axis and
//   angle (Q4.12 components, Q3.13 radians, clamped to plus or minus pi).
//   m_valid/m_ready/m_item return one transfer per item: the rotated vector,
//   Q4.12, saturated, in the order the items came in.
//   throughput: one item per cycle while m_ready is high.
//   CORDIC_STEPS is capped at 30; one cordic pipeline stage per step sets
//   the pipeline depth.
//   a stalled receiver freezes the back pipeline; the front keeps taking
//   transfers into a QUEUE_DEPTH entry queue and its own output register
//   until both fill, then drops s_ready.
//   reset (aresetn low, synchronous) empties the pipeline and queue; no
//   clearing pass, s_ready is high the cycle after reset.
//   items are independent, nothing is held between them.
module axis_angle_vector_rotate_core #(
    parameter int CORDIC_STEPS = aavr_pkg::CORDIC_STEPS_DEF,
    parameter int QUEUE_DEPTH  = aavr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  aavr_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output aavr_pkg::out_item_t m_item
);

    logic           fq_valid;
    logic           fq_ready;
    aavr_pkg::job_t fq_job;
    logic           qb_valid;
    logic           qb_ready;
    aavr_pkg::job_t qb_job;

    aavr_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_job   (fq_job)
    );

    aavr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    aavr_back #(
        .STEPS (CORDIC_STEPS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (qb_valid),
        .in_ready (qb_ready),
        .in_job   (qb_job),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule
